[sv/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate helper for the hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } out_item_t;

  // Request from the front part to the compression back part
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } blk_req_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam int unsigned LenPos  = 56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[sv/sha_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of parameterized type.
// ----------------------------------------------------------------------------
interface sha_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/sha256_hash_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with a packing/padding front, a block queue and a
// one-round-per-cycle compression unit.
// Throughput: one request per cycle while a block fills; a full block stalls
//   the input until the compression unit takes it from the queue.
// Output: first digest word valid once the last padding block after the end
//   request is compressed, plus any wait for an earlier block; then one word/cycle while out_ready is high.
// Reset (rst, synchronous): chain words to initial values, length to zero.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit (
  input logic clk,
  input logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  import sha_pkg::*;

  logic     req_valid;
  blk_req_t req;
  logic     q_space;
  logic     q_valid;
  logic     q_ready;
  blk_req_t q_data;

  sha_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .req_valid(req_valid), .req_ready(q_space), .req(req)
  );

  sha_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(req_valid), .wr_data(req), .space(q_space),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  sha_core u_core (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload)
  );

endmodule

[sv/sha_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front part
// Packs message bytes into blocks, counts length, builds padding blocks and
// queues block requests for the compression unit.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::in_item_t in_item,
  output logic              req_valid,
  input  logic              req_ready,
  output sha_pkg::blk_req_t req
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_FILL, S_PAD1, S_PAD2} state_t;

  state_t       state;
  logic [511:0] block;
  logic [60:0]  message_bytes;
  logic         byte_take;
  logic [5:0]   pos;
  logic [511:0] blk_with;
  logic [511:0] pad_blk;
  logic [63:0]  bit_len;
  logic         need_extra;

  assign pos       = message_bytes[5:0];
  assign bit_len   = {message_bytes, 3'b000};
  assign in_ready  = (state == S_FILL) && req_ready;
  assign byte_take = in_valid && in_ready && in_item.byte_present;

  // Block after inserting the incoming byte
  always_comb begin
    blk_with = block;
    if (in_item.byte_present)
      blk_with[511 - 8*pos -: 8] = in_item.data_byte;
  end

  // Padding block for the current length (pos is next free byte)
  always_comb begin
    pad_blk = block;
    for (int i = 0; i < 64; i++) begin
      if (i == int'(pos)) pad_blk[511 - 8*i -: 8] = PadByte;
      else if (i > int'(pos)) pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    need_extra = (int'(pos) + 1 > LenPos);
    if (!need_extra)
      pad_blk[63:0] = bit_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      message_bytes <= '0;
      req_valid     <= 1'b0;
    end else begin
      case (state)
        S_FILL: begin
          // full block goes out as soon as its last byte is taken
          req_valid <= byte_take && (pos == 6'd63);
          if (in_valid && in_ready) begin
            block <= blk_with;
            if (byte_take) begin
              message_bytes <= message_bytes + 61'd1;
              if (pos == 6'd63) begin
                req.block <= blk_with;
                req.last  <= 1'b0;
              end
            end
            if (in_item.end_of_message) state <= S_PAD1;
          end
        end
        S_PAD1: begin
          req_valid <= req_ready;
          if (req_ready) begin
            req.block <= pad_blk;
            req.last  <= !need_extra;
            if (need_extra) begin
              state <= S_PAD2;
            end else begin
              state         <= S_FILL;
              message_bytes <= '0;
            end
          end
        end
        S_PAD2: begin
          req_valid <= req_ready;
          if (req_ready) begin
            req.block     <= {448'b0, bit_len};
            req.last      <= 1'b1;
            state         <= S_FILL;
            message_bytes <= '0;
          end
        end
        default: begin
          req_valid <= 1'b0;
          state     <= S_FILL;
        end
      endcase
    end
  end

  // A request is only issued when the queue had space
  a_req_space: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> $past(req_ready)) else $error("request without queue space");
  a_len_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD2 && req_ready) |=> message_bytes == '0)
    else $error("length not cleared");
  a_no_take_pad: assert property (@(posedge clk) disable iff (rst)
    state != S_FILL |-> !in_ready) else $error("input taken during padding");

endmodule

[sv/sha_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of block requests between the front and the compression unit.
// Ready is held low whenever an extra request in flight could overflow it.
// ----------------------------------------------------------------------------
module sha_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  sha_pkg::blk_req_t wr_data,
  output logic              space,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha_pkg::blk_req_t rd_data
);
  import sha_pkg::*;

  blk_req_t   slots [QueueDepth];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign pop      = rd_valid && rd_ready;
  // one request may be in flight from the front's output register
  assign space    = (count == 2'd0) && !wr_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (wr_valid) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, wr_valid} - {1'b0, pop};
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (count < 2'd2)) else $error("queue overflow");
  a_cnt_rng: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !wr_valid) |=> count == $past(count) - 2'd1) else $error("bad pop count");

endmodule

[sv/sha_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One round per cycle with a 16-word schedule window; adds into the chain
// words and emits the digest after the last block of a message.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sha_pkg::blk_req_t  req,
  output logic               out_valid,
  input  logic               out_ready,
  output sha_pkg::out_item_t out_item
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_EMIT} state_t;

  state_t      state;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic        last;
  logic [2:0]  wnum;

  logic [31:0] t1, t2, s0, s1, w_new;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= InitH[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= req.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            last  <= req.last;
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (last) begin
            state              <= S_EMIT;
            wnum               <= '0;
            out_valid          <= 1'b1;
            out_item.digest_word <= h[0] + v[0];
            out_item.word_number <= '0;
            out_item.final_word  <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (wnum == 3'd7) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
              for (int i = 0; i < 8; i++) h[i] <= InitH[i];
            end else begin
              wnum                 <= wnum + 3'd1;
              out_item.digest_word <= h[wnum + 3'd1];
              out_item.word_number <= wnum + 3'd1;
              out_item.final_word  <= (wnum == 3'd6);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) == out_valid) else $error("output valid mismatch");
  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.final_word == (out_item.word_number == 3'd7)))
    else $error("final flag mismatch");
  a_num: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.word_number == wnum) else $error("word number mismatch");

endmodule
